// File: design/lzss_pkg.sv
// Shared types and constants of the LZSS decompressor.
// No dependencies; the interfaces and the decompressor import this package.

package lzss_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] phase_t;

    localparam int unsigned WIN_BITS = 12;

    localparam logic [WIN_BITS-1:0] WIN_START = 12'hFEE;
    localparam logic [4:0] MATCH_BASE = 5'd3;

    // Token phase codes.
    localparam phase_t PH_IDLE = 2'd0;
    localparam phase_t PH_TOKEN = 2'd1;
    localparam phase_t PH_MATCH2 = 2'd2;

endpackage

// File: design/lzss_if.sv
// Valid/ready stream interfaces for the compressed input and the decoded output.
// Depends on lzss_pkg for the byte type.

interface lzss_in_if
    import lzss_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzss_out_if
    import lzss_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// File: design/lzss_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module lzss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/lzss_decompressor.sv
// LZSS decompressor top level: token decoder, match copy engine and output register.
// Depends on lzss_pkg, lzss_in_if, lzss_out_if and lzss_ram.
// A literal is emitted in the cycle after its beat is accepted. A match reads its bytes
// through the registered RAM read port into the output register, one byte per cycle while
// the output is taken, bounded by the single read port of the window RAM.
// Reset and every last beat start a clearing pass over all WINDOW_SIZE entries (4096) that zeroes
// the window while no input beat is accepted.

module lzss_decompressor
    import lzss_pkg::*;
#(
    parameter int unsigned WINDOW_SIZE = 4096
) (
    input logic       clk,
    input logic       rst_n,
    lzss_in_if.sink   compressed,
    lzss_out_if.source decoded
);

    localparam int unsigned AW = $clog2(WINDOW_SIZE);
    localparam logic [AW-1:0] WP_START = AW'(WIN_START);
    localparam logic [AW-1:0] ADDR_MAX = AW'(WINDOW_SIZE - 1);

    phase_t        phase_reg, phase_next;
    logic [8:0]    flag_reg, flag_next;
    byte_t         pol_reg, pol_next;
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [4:0]    cnt_reg;
    logic          pend_reg;
    logic          fwd_reg;
    byte_t         fwd_data_reg;
    logic          last_pend_reg;
    logic          clr_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          out_valid_reg;
    byte_t         out_byte_reg;
    logic          run_last_reg;

    logic          advance, busy, acc;
    logic          lit, start_match;
    logic          lit_wr, eng_wr, issue, clr_start;
    logic [7:0]    v;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] offset;
    logic [4:0]    len;
    byte_t         eng_data;
    byte_t         ram_rdata;
    logic          we;
    logic [AW-1:0] waddr;
    byte_t         wdata;

    assign advance = !out_valid_reg || decoded.ready;
    assign busy = pend_reg || (cnt_reg != 5'd0);
    assign compressed.ready = !clr_reg && !busy && advance;
    assign acc = compressed.valid && compressed.ready;

    assign offset = AW'({compressed.in_byte[3:0], pol_reg});
    assign len = {1'b0, compressed.in_byte[7:4]} + MATCH_BASE;
    assign v = flag_reg[8:1];

    always_comb
    begin
        lit = 1'b0;
        start_match = 1'b0;
        phase_next = PH_IDLE;
        flag_next = flag_reg;
        pol_next = pol_reg;
        unique case (phase_reg)
            PH_MATCH2:
            begin
                start_match = 1'b1;
            end
            PH_TOKEN:
            begin
                if (flag_reg[0])
                begin
                    lit = 1'b1;
                end
                else
                begin
                    pol_next = compressed.in_byte;
                    phase_next = PH_MATCH2;
                end
            end
            default:
            begin
                if (v <= 8'd1)
                begin
                    flag_next = {1'b1, compressed.in_byte};
                    phase_next = PH_TOKEN;
                end
                else
                begin
                    flag_next = {1'b0, v};
                    if (v[0])
                    begin
                        lit = 1'b1;
                    end
                    else
                    begin
                        pol_next = compressed.in_byte;
                        phase_next = PH_MATCH2;
                    end
                end
            end
        endcase
        if (compressed.in_last)
        begin
            phase_next = PH_IDLE;
            flag_next = 9'd0;
            pol_next = 8'd0;
        end
    end

    assign lit_wr = acc && lit;
    assign eng_wr = pend_reg && advance;
    assign eng_data = fwd_reg ? fwd_data_reg : ram_rdata;
    assign issue = (acc && start_match) || ((cnt_reg != 5'd0) && advance);
    assign rd_addr = (acc && start_match) ? offset : rd_addr_reg;
    assign clr_start = (acc && compressed.in_last && !start_match)
                       || (eng_wr && (cnt_reg == 5'd0) && last_pend_reg);

    assign we = clr_reg || lit_wr || eng_wr;
    assign waddr = clr_reg ? clr_addr_reg : wp_reg;
    assign wdata = clr_reg ? 8'd0 : (lit_wr ? compressed.in_byte : eng_data);

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            flag_reg <= 9'd0;
            pol_reg <= 8'd0;
            wp_reg <= WP_START;
            rd_addr_reg <= '0;
            cnt_reg <= 5'd0;
            pend_reg <= 1'b0;
            fwd_reg <= 1'b0;
            last_pend_reg <= 1'b0;
            clr_reg <= 1'b1;
            clr_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                phase_reg <= phase_next;
                flag_reg <= flag_next;
                pol_reg <= pol_next;
            end

            if (acc && start_match)
            begin
                cnt_reg <= len - 5'd1;
                last_pend_reg <= compressed.in_last;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg - 5'd1;
            end
            if (issue)
            begin
                rd_addr_reg <= rd_addr + AW'(1);
                fwd_reg <= eng_wr && (rd_addr == wp_reg);
                pend_reg <= 1'b1;
            end
            else if (eng_wr)
            begin
                pend_reg <= 1'b0;
            end

            if (clr_start)
            begin
                clr_reg <= 1'b1;
                clr_addr_reg <= '0;
                last_pend_reg <= 1'b0;
            end
            else if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == ADDR_MAX)
                begin
                    clr_reg <= 1'b0;
                end
            end

            if (clr_reg && (clr_addr_reg == ADDR_MAX))
            begin
                wp_reg <= WP_START;
            end
            else if (lit_wr || eng_wr)
            begin
                wp_reg <= wp_reg + AW'(1);
            end

            if (lit_wr || eng_wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (decoded.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            fwd_data_reg <= wdata;
        end
        if (lit_wr || eng_wr)
        begin
            out_byte_reg <= wdata;
            run_last_reg <= lit_wr || (cnt_reg == 5'd0);
        end
    end

    assign decoded.valid = out_valid_reg;
    assign decoded.out_byte = out_byte_reg;
    assign decoded.run_last = run_last_reg;

    a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !compressed.ready)
        else $error("input beat offered while the window is being cleared");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(lit_wr && eng_wr) && !(clr_reg && (lit_wr || eng_wr)))
        else $error("two sources write the window in the same cycle");

    a_no_output_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (lit_wr || eng_wr) |-> (!out_valid_reg || decoded.ready))
        else $error("output register overwritten before its beat was taken");

    a_match_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && start_match) |=> !compressed.ready)
        else $error("input accepted while a match copy is running");

    a_run_ends_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_wr && (cnt_reg == 5'd0)) |=> (decoded.valid && decoded.run_last))
        else $error("final byte of a match not marked as run end");

endmodule
